>>> hw/rtl/lca_binary_lifting_assert.svh
// Assertion macros for the checker file of the lifting block.
`ifndef LCA_BINARY_LIFTING_ASSERT_SVH
`define LCA_BINARY_LIFTING_ASSERT_SVH

// Clocked check, skipped while reset is applied.
`define LCAB_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LCAB_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/lcab_pkg.sv
// Shared constants for the lowest-common-ancestor block.
`default_nettype none
package lcab_pkg;
	localparam int NODE_W    = 10;
	localparam int LEVELS    = 10;
	localparam int LVL_W     = $clog2(LEVELS);
	localparam int MAX_NODES = 1 << NODE_W;
	localparam int A_DEPTH   = LEVELS * MAX_NODES;
	localparam int A_AW      = LVL_W + NODE_W;
	localparam int B_W       = NODE_W + 1;

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_BUILD = 2'd2;
	localparam logic [1:0] MODE_QUERY = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_RANGE   = 2'd1;
	localparam logic [1:0] STAT_UNBUILT = 2'd2;
endpackage
`default_nettype wire

>>> hw/rtl/lcab_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lcab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> hw/rtl/lca_binary_lifting.sv
// Top level: lowest-common-ancestor engine by binary lifting over two RAMs.
// Load, errored and equal-node queries finish at once; the unstallable done strobes next cycle.
// Query: read both depths, lift the deeper node to the other's depth, finish if they meet,
// else lift both; each step waits on one registered RAM read. Clear: sweeps, one node per cycle.
// Build: zero depths and find the root, run depth passes, then fill the tables level by level.
// Reset clears control state, then sweeps the node RAM with busy high.
`default_nettype none
module lca_binary_lifting (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  mode,
	input  wire logic [lcab_pkg::NODE_W-1:0] node_a,
	input  wire logic [lcab_pkg::NODE_W-1:0] node_b,
	output logic                             done,
	output logic      [lcab_pkg::NODE_W-1:0] ancestor,
	output logic      [1:0]                  status,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [lcab_pkg::NODE_W-1:0] cfg_data
);
	localparam int NW = lcab_pkg::NODE_W;
	localparam int LW = lcab_pkg::LVL_W;
	localparam int AW = lcab_pkg::A_AW;
	localparam int BW = lcab_pkg::B_W;
	localparam logic [LW-1:0] LVL_TOP = LW'(lcab_pkg::LEVELS - 1);
	localparam logic [NW-1:0] NODE_ONE = NW'(1);

	// Sequencer codes: clear sweep, idle, build phases, query phases.
	localparam logic [4:0] S_CLR  = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_RRD  = 5'd2;
	localparam logic [4:0] S_RWR  = 5'd3;
	localparam logic [4:0] S_ROOT = 5'd4;
	localparam logic [4:0] S_P1   = 5'd5;
	localparam logic [4:0] S_P2   = 5'd6;
	localparam logic [4:0] S_P3   = 5'd7;
	localparam logic [4:0] S_L1   = 5'd8;
	localparam logic [4:0] S_L2   = 5'd9;
	localparam logic [4:0] S_L3   = 5'd10;
	localparam logic [4:0] S_QDU  = 5'd11;
	localparam logic [4:0] S_QDV  = 5'd12;
	localparam logic [4:0] S_QSW  = 5'd13;
	localparam logic [4:0] S_QL1  = 5'd14;
	localparam logic [4:0] S_QL2  = 5'd15;
	localparam logic [4:0] S_QL3  = 5'd16;
	localparam logic [4:0] S_QEQ  = 5'd17;
	localparam logic [4:0] S_QM1  = 5'd18;
	localparam logic [4:0] S_QM2  = 5'd19;
	localparam logic [4:0] S_QM3  = 5'd20;
	localparam logic [4:0] S_QFIN = 5'd21;
	localparam logic [4:0] S_QOUT = 5'd22;

	logic [4:0]    state_q;
	logic [NW-1:0] idx_q, root_q, u_q, v_q, du_q, dv_q, x_q, count_q;
	logic [LW-1:0] lvl_q;
	logic          changed_q, zero_q, built_q;
	logic          done_q;
	logic [NW-1:0] ancestor_q;
	logic [1:0]    status_q;

	// Ancestor RAM: address is {level, node}. Node RAM: {has_parent, depth}.
	logic          a_we, b_we;
	logic [AW-1:0] a_waddr, a_raddr;
	logic [NW-1:0] a_wdata, a_rdata;
	logic [NW-1:0] b_waddr, b_raddr;
	logic [BW-1:0] b_wdata, b_rdata;
	logic          b_hp;
	logic [NW-1:0] b_dep;
	logic [LW-1:0] lvl_dn;

	logic accept, valid_a, valid_b, p_ok;
	logic step_node, step_chg, step_zero, pass_chg, pass_zero;

	lcab_ram #(.WIDTH(NW), .DEPTH(lcab_pkg::A_DEPTH), .AW(AW)) u_anc (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.raddr(a_raddr), .rdata(a_rdata)
	);

	lcab_ram #(.WIDTH(BW), .DEPTH(lcab_pkg::MAX_NODES), .AW(NW)) u_node (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr(b_raddr), .rdata(b_rdata)
	);

	assign b_hp   = b_rdata[BW-1];
	assign b_dep  = b_rdata[NW-1:0];
	assign lvl_dn = lvl_q - LW'(1);

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign valid_a   = (node_a != '0) && (node_a <= count_q);
	assign valid_b   = (node_b != '0) && (node_b <= count_q);
	// Parent read from level zero must be a live node to carry depth.
	assign p_ok      = (a_rdata != '0) && (a_rdata <= count_q);

	assign done     = done_q;
	assign ancestor = ancestor_q;
	assign status   = status_q;

	// RAM port drive per sequencer step.
	always_comb begin
		a_we    = 1'b0;
		a_waddr = '0;
		a_wdata = '0;
		a_raddr = '0;
		b_we    = 1'b0;
		b_waddr = '0;
		b_wdata = '0;
		b_raddr = '0;
		unique case (state_q)
			S_CLR: begin
				b_we    = 1'b1;
				b_waddr = idx_q;
			end
			S_IDLE: begin
				// Load a child-parent word; it also zeroes the child's depth.
				if (accept && mode == lcab_pkg::MODE_LOAD && valid_a && valid_b) begin
					a_we    = 1'b1;
					a_waddr = {LW'(0), node_a};
					a_wdata = node_b;
					b_we    = 1'b1;
					b_waddr = node_a;
					b_wdata = {1'b1, NW'(0)};
				end
			end
			S_RRD: b_raddr = idx_q;
			S_RWR: begin
				b_we    = 1'b1;
				b_waddr = idx_q;
				b_wdata = {b_hp, NW'(0)};
			end
			S_ROOT: begin
				if (root_q != '0) begin
					a_we    = 1'b1;
					a_waddr = {LW'(0), root_q};
					a_wdata = root_q;
					b_we    = 1'b1;
					b_waddr = root_q;
					b_wdata = {1'b0, NODE_ONE};
				end
			end
			S_P1: begin
				b_raddr = idx_q;
				a_raddr = {LW'(0), idx_q};
			end
			S_P2: b_raddr = a_rdata;
			S_P3: begin
				if (b_dep != '0) begin
					b_we    = 1'b1;
					b_waddr = idx_q;
					b_wdata = {1'b1, b_dep + NODE_ONE};
				end
			end
			S_L1: a_raddr = {lvl_dn, idx_q};
			S_L2: a_raddr = {lvl_dn, a_rdata};
			S_L3: begin
				a_we    = 1'b1;
				a_waddr = {lvl_q, idx_q};
				a_wdata = a_rdata;
			end
			S_QDU: b_raddr = u_q;
			S_QDV: b_raddr = v_q;
			S_QL1: a_raddr = {lvl_q, u_q};
			S_QL2: b_raddr = a_rdata;
			S_QM1: a_raddr = {lvl_q, u_q};
			S_QM2: a_raddr = {lvl_q, v_q};
			S_QFIN: a_raddr = {LW'(0), u_q};
			default: ;
		endcase
	end

	// Depth pass bookkeeping: a node is finished, gained a depth, or stays unreached.
	always_comb begin
		step_node = 1'b0;
		step_chg  = 1'b0;
		step_zero = 1'b0;
		case (state_q)
			S_P2: begin
				if (b_dep != '0) begin
					step_node = 1'b1;
				end else if (!b_hp || !p_ok) begin
					step_node = 1'b1;
					step_zero = 1'b1;
				end
			end
			S_P3: begin
				step_node = 1'b1;
				if (b_dep != '0) begin
					step_chg = 1'b1;
				end else begin
					step_zero = 1'b1;
				end
			end
			default: ;
		endcase
		pass_chg  = changed_q | step_chg;
		pass_zero = zero_q | step_zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			idx_q     <= '0;
			count_q   <= NODE_ONE;
			built_q   <= 1'b0;
			changed_q <= 1'b0;
			zero_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
				built_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					// Sweep every node entry, dropping has_parent.
					idx_q <= idx_q + NODE_ONE;
					if (idx_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (mode)
							lcab_pkg::MODE_CLEAR: begin
								built_q <= 1'b0;
								idx_q   <= '0;
								state_q <= S_CLR;
							end
							lcab_pkg::MODE_LOAD: begin
								if (valid_a && valid_b) begin
									built_q <= 1'b0;
								end
							end
							lcab_pkg::MODE_BUILD: begin
								built_q <= 1'b0;
								idx_q   <= NODE_ONE;
								root_q  <= '0;
								if (count_q != '0) begin
									state_q <= S_RRD;
								end
							end
							lcab_pkg::MODE_QUERY: begin
								if (!valid_a || !valid_b) begin
									done_q     <= 1'b1;
									ancestor_q <= '0;
									status_q   <= lcab_pkg::STAT_RANGE;
								end else if (!built_q) begin
									done_q     <= 1'b1;
									ancestor_q <= '0;
									status_q   <= lcab_pkg::STAT_UNBUILT;
								end else if (node_a == node_b) begin
									done_q     <= 1'b1;
									ancestor_q <= node_a;
									status_q   <= lcab_pkg::STAT_OK;
								end else begin
									u_q     <= node_a;
									v_q     <= node_b;
									state_q <= S_QDU;
								end
							end
							default: ;
						endcase
					end
				end
				S_RRD: state_q <= S_RWR;
				S_RWR: begin
					// First parentless node is the root; depth is zeroed as we go.
					if (root_q == '0 && !b_hp) begin
						root_q <= idx_q;
					end
					if (idx_q == count_q) begin
						state_q <= S_ROOT;
					end else begin
						idx_q   <= idx_q + NODE_ONE;
						state_q <= S_RRD;
					end
				end
				S_ROOT: begin
					idx_q     <= NODE_ONE;
					changed_q <= 1'b0;
					zero_q    <= 1'b0;
					state_q   <= (root_q == '0) ? S_IDLE : S_P1;
				end
				S_P1: state_q <= S_P2;
				S_P2, S_P3: begin
					if (!step_node) begin
						state_q <= S_P3;
					end else if (idx_q == count_q) begin
						idx_q     <= NODE_ONE;
						changed_q <= 1'b0;
						zero_q    <= 1'b0;
						if (pass_chg) begin
							state_q <= S_P1;
						end else if (pass_zero) begin
							state_q <= S_IDLE;
						end else begin
							lvl_q   <= LW'(1);
							state_q <= S_L1;
						end
					end else begin
						idx_q     <= idx_q + NODE_ONE;
						changed_q <= pass_chg;
						zero_q    <= pass_zero;
						state_q   <= S_P1;
					end
				end
				S_L1: state_q <= S_L2;
				S_L2: state_q <= S_L3;
				S_L3: begin
					if (idx_q == count_q) begin
						idx_q <= NODE_ONE;
						if (lvl_q == LVL_TOP) begin
							built_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							lvl_q   <= lvl_q + LW'(1);
							state_q <= S_L1;
						end
					end else begin
						idx_q   <= idx_q + NODE_ONE;
						state_q <= S_L1;
					end
				end
				S_QDU: state_q <= S_QDV;
				S_QDV: begin
					du_q    <= b_dep;
					state_q <= S_QSW;
				end
				S_QSW: begin
					// Keep the deeper node in u.
					if (du_q < b_dep) begin
						u_q  <= v_q;
						v_q  <= u_q;
						dv_q <= du_q;
					end else begin
						dv_q <= b_dep;
					end
					lvl_q   <= LVL_TOP;
					state_q <= S_QL1;
				end
				S_QL1: state_q <= S_QL2;
				S_QL2: begin
					x_q     <= a_rdata;
					state_q <= S_QL3;
				end
				S_QL3: begin
					if (b_dep >= dv_q) begin
						u_q <= x_q;
					end
					lvl_q   <= lvl_dn;
					state_q <= (lvl_q == '0) ? S_QEQ : S_QL1;
				end
				S_QEQ: begin
					if (u_q == v_q) begin
						done_q     <= 1'b1;
						ancestor_q <= u_q;
						status_q   <= lcab_pkg::STAT_OK;
						state_q    <= S_IDLE;
					end else begin
						lvl_q   <= LVL_TOP;
						state_q <= S_QM1;
					end
				end
				S_QM1: state_q <= S_QM2;
				S_QM2: begin
					x_q     <= a_rdata;
					state_q <= S_QM3;
				end
				S_QM3: begin
					if (x_q != a_rdata) begin
						u_q <= x_q;
						v_q <= a_rdata;
					end
					lvl_q   <= lvl_dn;
					state_q <= (lvl_q == '0) ? S_QFIN : S_QM1;
				end
				S_QFIN: state_q <= S_QOUT;
				S_QOUT: begin
					done_q     <= 1'b1;
					ancestor_q <= a_rdata;
					status_q   <= lcab_pkg::STAT_OK;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/lcab_checker.sv
// Port-level checks for the lifting block, bound to the top level.
`default_nettype none
`include "lca_binary_lifting_assert.svh"
module lcab_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic [1:0]                  mode,
	input wire logic [lcab_pkg::NODE_W-1:0] node_a,
	input wire logic [lcab_pkg::NODE_W-1:0] node_b,
	input wire logic                        done,
	input wire logic [lcab_pkg::NODE_W-1:0] ancestor,
	input wire logic [1:0]                  status,
	input wire logic                        cfg_valid,
	input wire logic                        cfg_ready,
	input wire logic [lcab_pkg::NODE_W-1:0] cfg_data
);
	logic err_word, take_cmd, take_zero;

	assign err_word  = done && status != lcab_pkg::STAT_OK;
	assign take_cmd  = start && !busy && mode != lcab_pkg::MODE_QUERY;
	assign take_zero = start && !busy && mode == lcab_pkg::MODE_QUERY && node_a == '0;

	`LCAB_ASSERT(a_err_zero, err_word |-> (ancestor == '0), "error word carries an ancestor")
	`LCAB_ASSERT(a_noresult, take_cmd |=> !done, "word from a non-query command")
	`LCAB_ASSERT_ALWAYS(a_done_idle, done |-> !busy, "result shown while still working")
	`LCAB_ASSERT(a_range_zero, take_zero |=> (done && status == lcab_pkg::STAT_RANGE), "node zero")
endmodule

bind lca_binary_lifting lcab_checker u_lcab_checker (.*);
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the binary-lifting lowest-common-ancestor block.
`timescale 1ns / 100ps
module tb_top;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int LEVELS      = lcab_pkg::LEVELS;
	localparam int MAX_NODES   = lcab_pkg::MAX_NODES;

	// Result word as the block should report it for one query
	typedef struct packed {
		logic [9:0] anc;
		logic [1:0] st;
	} lca_word_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] mode;
	logic [9:0] node_a;
	logic [9:0] node_b;
	logic       done;
	logic [9:0] ancestor;
	logic [1:0] status;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [9:0] cfg_data;

	lca_binary_lifting dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .node_a(node_a), .node_b(node_b),
		.done(done), .ancestor(ancestor), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Shadow copy of the tree store, tables and node count
	logic [9:0] sh_anc [LEVELS][MAX_NODES];
	logic [9:0] sh_depth [MAX_NODES];
	bit         sh_has_par [MAX_NODES];
	bit         sh_built;
	logic [9:0] sh_count;

	lca_word_t  lca_due[$];
	int         n_errors;
	int         n_words;
	int         n_queries;
	int         n_builds_ok;
	int         n_builds_bad;
	int         n_cycles;
	bit         gaps_on;

	// Scratch for tree generation
	int         lbl [MAX_NODES];
	int         par_idx [MAX_NODES];
	int         ord [MAX_NODES];

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic bit node_ok(input logic [9:0] n);
		return n >= 1 && n <= sh_count && n < MAX_NODES;
	endfunction

	// Find the root, assign depths, fill the lifting tables
	function automatic void rebuild_tables();
		int  root;
		int  lim;
		bit  changed;
		int  p;
		lim = sh_count;
		root = 0;
		sh_built = 0;
		for (int i = 1; i <= lim; i++) begin
			sh_depth[i] = '0;
			if (root == 0 && !sh_has_par[i])
				root = i;
		end
		if (root == 0) begin
			n_builds_bad++;
			return;
		end
		sh_anc[0][root] = root[9:0];
		sh_depth[root] = 10'd1;
		do begin
			changed = 0;
			for (int i = 1; i <= lim; i++) begin
				if (sh_depth[i] != 0 || !sh_has_par[i])
					continue;
				p = sh_anc[0][i];
				if (p >= 1 && p <= lim && sh_depth[p] != 0) begin
					sh_depth[i] = sh_depth[p] + 10'd1;
					changed = 1;
				end
			end
		end while (changed);
		for (int i = 1; i <= lim; i++)
			if (sh_depth[i] == 0) begin
				n_builds_bad++;
				return;
			end
		for (int j = 1; j < LEVELS; j++)
			for (int i = 1; i <= lim; i++)
				sh_anc[j][i] = sh_anc[j-1][sh_anc[j-1][i]];
		sh_built = 1;
		n_builds_ok++;
	endfunction

	function automatic logic [9:0] lift_lca(input logic [9:0] a, input logic [9:0] b);
		logic [9:0] u;
		logic [9:0] v;
		logic [9:0] t;
		u = a;
		v = b;
		if (sh_depth[u] < sh_depth[v]) begin
			t = u;
			u = v;
			v = t;
		end
		for (int lv = LEVELS - 1; lv >= 0; lv--)
			if (sh_depth[sh_anc[lv][u]] >= sh_depth[v])
				u = sh_anc[lv][u];
		if (u == v)
			return u;
		for (int lv = LEVELS - 1; lv >= 0; lv--)
			if (sh_anc[lv][u] != sh_anc[lv][v]) begin
				u = sh_anc[lv][u];
				v = sh_anc[lv][v];
			end
		return sh_anc[0][u];
	endfunction

	// Advance the shadow state by one accepted word
	function automatic void apply_word(input logic [1:0] m, input logic [9:0] a,
			input logic [9:0] b);
		lca_word_t w;
		case (m)
			lcab_pkg::MODE_CLEAR: begin
				for (int i = 0; i < MAX_NODES; i++)
					sh_has_par[i] = 0;
				sh_built = 0;
			end
			lcab_pkg::MODE_LOAD: begin
				if (node_ok(a) && node_ok(b)) begin
					sh_anc[0][a] = b;
					sh_has_par[a] = 1;
					sh_built = 0;
				end
			end
			lcab_pkg::MODE_BUILD: rebuild_tables();
			default: begin
				n_queries++;
				if (!node_ok(a) || !node_ok(b)) begin
					w.anc = '0;
					w.st = lcab_pkg::STAT_RANGE;
				end else if (!sh_built) begin
					w.anc = '0;
					w.st = lcab_pkg::STAT_UNBUILT;
				end else begin
					w.anc = lift_lca(a, b);
					w.st = lcab_pkg::STAT_OK;
				end
				lca_due = {lca_due, w};
			end
		endcase
	endfunction

	// Drop start now and then, unless gaps are off
	task automatic maybe_gap();
		if (gaps_on && $urandom_range(0, 99) < 29) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Present one word and hold it until the block takes it
	task automatic send_word(input logic [1:0] m, input logic [9:0] a, input logic [9:0] b);
		start <= 1'b1;
		mode <= m;
		node_a <= a;
		node_b <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_word(m, a, b);
		n_words++;
		maybe_gap();
	endtask

	// Wait for every answer, then for the block to go quiet
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (lca_due.size() != 0 || busy)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_count(input logic [9:0] n);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= n;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sh_count = n;
		sh_built = 0;
		cfg_valid <= 1'b0;
		cfg_data <= $urandom_range(0, 1023);
		@(posedge clk);
	endtask

	// Check each answer against the oldest expectation
	always @(posedge clk) begin
		lca_word_t w;
		if (arst_n && done) begin
			if (lca_due.size() == 0) begin
				$error("answer with none expected: ancestor %0d status %0d", ancestor, status);
				n_errors++;
			end else begin
				w = lca_due.pop_front();
				if (ancestor !== w.anc) begin
					$error("ancestor: expected %0d, got %0d", w.anc, ancestor);
					n_errors++;
				end
				if (status !== w.st) begin
					$error("status: expected %0d, got %0d", w.st, status);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", n_cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Errors before any build, a single-node build, empty and full ranges
	task automatic test_unbuilt();
		send_word(lcab_pkg::MODE_QUERY, 10'd1, 10'd1);
		send_word(lcab_pkg::MODE_QUERY, 10'd0, 10'd1);
		send_word(lcab_pkg::MODE_QUERY, 10'd1023, 10'd1023);
		send_word(lcab_pkg::MODE_BUILD, 10'd0, 10'd0);
		send_word(lcab_pkg::MODE_QUERY, 10'd1, 10'd1);
		write_count(10'd0);
		send_word(lcab_pkg::MODE_BUILD, 10'd0, 10'd0);
		send_word(lcab_pkg::MODE_QUERY, 10'd1, 10'd0);
		write_count(10'd1023);
		send_word(lcab_pkg::MODE_QUERY, 10'd1023, 10'd512);
	endtask

	// Small hand-built tree: root 2, chain 2-5-7-3, branch 5-1, 7-6, 2-4
	task automatic test_small_tree();
		write_count(10'd7);
		send_word(lcab_pkg::MODE_CLEAR, 10'd0, 10'd0);
		send_word(lcab_pkg::MODE_LOAD, 10'd5, 10'd2);
		send_word(lcab_pkg::MODE_LOAD, 10'd7, 10'd5);
		send_word(lcab_pkg::MODE_LOAD, 10'd3, 10'd7);
		send_word(lcab_pkg::MODE_LOAD, 10'd1, 10'd5);
		send_word(lcab_pkg::MODE_LOAD, 10'd6, 10'd7);
		send_word(lcab_pkg::MODE_LOAD, 10'd4, 10'd2);
		send_word(lcab_pkg::MODE_LOAD, 10'd0, 10'd3);
		send_word(lcab_pkg::MODE_LOAD, 10'd4, 10'd8);
		send_word(lcab_pkg::MODE_BUILD, 10'd0, 10'd0);
		send_word(lcab_pkg::MODE_QUERY, 10'd3, 10'd6);
		send_word(lcab_pkg::MODE_QUERY, 10'd3, 10'd1);
		send_word(lcab_pkg::MODE_QUERY, 10'd1, 10'd3);
		send_word(lcab_pkg::MODE_QUERY, 10'd3, 10'd4);
		send_word(lcab_pkg::MODE_QUERY, 10'd6, 10'd6);
		send_word(lcab_pkg::MODE_QUERY, 10'd2, 10'd3);
		send_word(lcab_pkg::MODE_QUERY, 10'd7, 10'd3);
		send_word(lcab_pkg::MODE_QUERY, 10'd8, 10'd3);
		// reload drops the tables until the next build
		send_word(lcab_pkg::MODE_LOAD, 10'd6, 10'd3);
		send_word(lcab_pkg::MODE_QUERY, 10'd6, 10'd1);
		send_word(lcab_pkg::MODE_BUILD, 10'd0, 10'd0);
		send_word(lcab_pkg::MODE_QUERY, 10'd6, 10'd1);
	endtask

	// Builds that must fail: cycle, second root, parent pushed out of range
	task automatic test_broken_trees();
		send_word(lcab_pkg::MODE_LOAD, 10'd2, 10'd3);
		send_word(lcab_pkg::MODE_BUILD, 10'd0, 10'd0);
		send_word(lcab_pkg::MODE_QUERY, 10'd4, 10'd1);
		send_word(lcab_pkg::MODE_CLEAR, 10'd0, 10'd0);
		send_word(lcab_pkg::MODE_LOAD, 10'd2, 10'd1);
		send_word(lcab_pkg::MODE_LOAD, 10'd3, 10'd1);
		send_word(lcab_pkg::MODE_BUILD, 10'd0, 10'd0);
		send_word(lcab_pkg::MODE_QUERY, 10'd2, 10'd3);
		write_count(10'd9);
		send_word(lcab_pkg::MODE_CLEAR, 10'd0, 10'd0);
		for (int i = 1; i < 9; i++)
			send_word(lcab_pkg::MODE_LOAD, i[9:0], 10'd9);
		send_word(lcab_pkg::MODE_BUILD, 10'd0, 10'd0);
		send_word(lcab_pkg::MODE_QUERY, 10'd1, 10'd8);
		write_count(10'd8);
		send_word(lcab_pkg::MODE_BUILD, 10'd0, 10'd0);
		send_word(lcab_pkg::MODE_QUERY, 10'd1, 10'd8);
		send_word(lcab_pkg::MODE_CLEAR, 10'd0, 10'd0);
		send_word(lcab_pkg::MODE_QUERY, 10'd1, 10'd2);
	endtask

	// Random tree over nodes 1..n; labels shuffled unless in order
	task automatic load_random_tree(input int n, input bit chain, input bit in_order,
			input bit noisy);
		int j;
		int t;
		for (int k = 1; k <= n; k++) begin
			lbl[k] = k;
			ord[k] = k;
		end
		if (!in_order)
			for (int k = n; k > 1; k--) begin
				j = $urandom_range(1, k);
				t = lbl[k]; lbl[k] = lbl[j]; lbl[j] = t;
				j = $urandom_range(1, k);
				t = ord[k]; ord[k] = ord[j]; ord[j] = t;
			end
		for (int k = 2; k <= n; k++)
			par_idx[k] = chain ? k - 1 : $urandom_range(k > 4 && in_order ? k - 4 : 1, k - 1);
		send_word(lcab_pkg::MODE_CLEAR, 10'd0, 10'd0);
		for (int k = 1; k <= n; k++) begin
			if (ord[k] != 1)
				send_word(lcab_pkg::MODE_LOAD, lbl[ord[k]][9:0],
					lbl[par_idx[ord[k]]][9:0]);
			if (noisy && $urandom_range(0, 9) == 0)
				send_word(lcab_pkg::MODE_LOAD,
					$urandom_range(0, 1) ? 10'd0 : 10'($urandom_range(0, 1023)),
					10'($urandom_range(0, 1023)));
		end
		send_word(lcab_pkg::MODE_BUILD, 10'd0, 10'd0);
	endtask

	task automatic send_queries(input int n, input int cnt, input bit noisy);
		for (int q = 0; q < cnt; q++)
			if (noisy && $urandom_range(0, 9) == 0)
				send_word(lcab_pkg::MODE_QUERY, 10'($urandom_range(0, 1023)),
					10'($urandom_range(0, 1023)));
			else
				send_word(lcab_pkg::MODE_QUERY, 10'($urandom_range(1, n)),
					10'($urandom_range(1, n)));
	endtask

	// Mostly well-formed trees with random shapes, some broken or noisy
	task automatic test_random_trees();
		int start_words;
		int n;
		int ph;
		start_words = n_words;
		ph = 0;
		while (n_words - start_words < 250) begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : $urandom_range(6, 40);
			gaps_on = (ph % 4 != 1);
			write_count(n[9:0]);
			load_random_tree(n, $urandom_range(0, 4) == 0, 0, 1);
			case ($urandom_range(0, 9))
				0: send_word(lcab_pkg::MODE_LOAD, 10'($urandom_range(1, n)),
					10'($urandom_range(1, n)));
				1: send_word(lcab_pkg::MODE_CLEAR, 10'd0, 10'd0);
				2: begin
					send_word(lcab_pkg::MODE_LOAD, 10'($urandom_range(1, n)),
						10'($urandom_range(1, n)));
					send_word(lcab_pkg::MODE_BUILD, 10'd0, 10'd0);
				end
				default: ;
			endcase
			send_queries(n, $urandom_range(8, 20), 1);
			ph++;
		end
		gaps_on = 1;
	endtask

	// One large tree, labels in order so the build stays fast
	task automatic test_full_tree();
		write_count(10'd160);
		load_random_tree(160, 0, 1, 0);
		send_queries(160, 20, 0);
		send_word(lcab_pkg::MODE_QUERY, 10'd160, 10'd1);
		send_word(lcab_pkg::MODE_QUERY, 10'd160, 10'd159);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = lcab_pkg::MODE_CLEAR;
		node_a = '0;
		node_b = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		n_errors = 0;
		n_words = 0;
		n_queries = 0;
		n_builds_ok = 0;
		n_builds_bad = 0;
		n_cycles = 0;
		gaps_on = 1;
		for (int j = 0; j < LEVELS; j++)
			for (int i = 0; i < MAX_NODES; i++)
				sh_anc[j][i] = '0;
		for (int i = 0; i < MAX_NODES; i++) begin
			sh_depth[i] = '0;
			sh_has_par[i] = 0;
		end
		sh_built = 0;
		sh_count = 10'd1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unbuilt();
		test_small_tree();
		test_broken_trees();
		test_random_trees();
		test_full_tree();
		drain();
		if (lca_due.size() != 0) begin
			$error("%0d answers never arrived", lca_due.size());
			n_errors++;
		end

		$display("covered %0d words, %0d queries; %0d builds passed, %0d refused",
			n_words, n_queries, n_builds_ok, n_builds_bad);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
